/* hw/rtl/prc_pkg.sv */
// prc_pkg: shared constants and types for the prime range counter.
// No dependencies; used by the interfaces, the core and the checker.
package prc_pkg;

  // Default operand width of range bounds
  localparam int unsigned VALUE_BITS_DEF = 17;

  // First trial divisor and its square
  localparam int unsigned FIRST_DIVISOR = 2;
  localparam int unsigned FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CAND   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_NEXT   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

endpackage

/* hw/rtl/prc_if.sv */
// prc_if: valid/ready channel interfaces for request and result.
// Depends on prc_pkg for the default width.
interface prc_in_if #(
  parameter int unsigned VALUE_BITS = prc_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] range_start;
  logic [VALUE_BITS-1:0] range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface prc_out_if #(
  parameter int unsigned VALUE_BITS = prc_pkg::VALUE_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [VALUE_BITS:0] prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

/* hw/rtl/prime_range_counter_core.sv */
// Sequence: a request is taken in ST_IDLE; each candidate n then visits ST_CAND,
//   runs a bit-serial remainder in ST_DIV for each trial divisor d with d*d <= n
//   until one divides n, and ends in ST_NEXT; ST_FINISH then hands over the count.
// Throughput: one request at a time, as ready is high only in ST_IDLE.
// Reset: rst_n synchronous, active low; sequencer idles, result slot empty.
// prime_range_counter_core: counts primes in an inclusive range by trial
// division; depends on prc_pkg and the prc_in_if / prc_out_if interfaces.
module prime_range_counter_core #(
  parameter int unsigned VALUE_BITS = prc_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  prc_in_if.sink    in_req,
  prc_out_if.source out_res
);

  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned VB    = VALUE_BITS;

  prc_pkg::state_t state_r, state_nxt;

  logic [VB-1:0]    cand_r, cand_nxt;     // candidate value
  logic [VB-1:0]    hi_r, hi_nxt;         // last value of range
  logic [VB-1:0]    div_r, div_nxt;       // trial divisor
  logic [VB:0]      sq_r, sq_nxt;         // divisor squared
  logic [VB:0]      count_r, count_nxt;   // running prime count
  logic [VB-1:0]    rem_r, rem_nxt;       // partial remainder
  logic [VB-1:0]    shf_r, shf_nxt;       // dividend bits still to shift in
  logic [CNT_W-1:0] bit_r, bit_nxt;       // remainder step counter
  logic             out_valid_r, out_valid_nxt;
  logic [VB:0]      out_count_r, out_count_nxt;

  // shared remainder step: one restoring subtract per cycle
  logic [VB:0] trial;
  logic        trial_ge;
  logic [VB:0] trial_diff;

  assign trial      = {rem_r, shf_r[VB-1]};
  assign trial_ge   = trial >= {1'b0, div_r};
  assign trial_diff = trial - {1'b0, div_r};

  assign in_req.ready        = (state_r == prc_pkg::ST_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.prime_count = out_count_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    hi_nxt        = hi_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    shf_nxt       = shf_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      prc_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          cand_nxt  = in_req.range_start;
          hi_nxt    = in_req.range_end;
          count_nxt = '0;
          div_nxt   = VB'(prc_pkg::FIRST_DIVISOR);
          sq_nxt    = (VB + 1)'(prc_pkg::FIRST_SQUARE);
          if (in_req.range_start > in_req.range_end) begin
            state_nxt = prc_pkg::ST_FINISH;
          end else begin
            state_nxt = prc_pkg::ST_CAND;
          end
        end
      end
      prc_pkg::ST_CAND: begin
        if (cand_r < VB'(prc_pkg::FIRST_DIVISOR)) begin
          state_nxt = prc_pkg::ST_NEXT;
        end else if (sq_r > {1'b0, cand_r}) begin
          // no divisor found: prime
          count_nxt = count_r + 1'b1;
          state_nxt = prc_pkg::ST_NEXT;
        end else begin
          rem_nxt   = '0;
          shf_nxt   = cand_r;
          bit_nxt   = CNT_W'(VB - 1);
          state_nxt = prc_pkg::ST_DIV;
        end
      end
      prc_pkg::ST_DIV: begin
        rem_nxt = trial_ge ? trial_diff[VB-1:0] : trial[VB-1:0];
        shf_nxt = {shf_r[VB-2:0], 1'b0};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          if (rem_nxt == '0) begin
            state_nxt = prc_pkg::ST_NEXT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {div_r, 1'b1};
            div_nxt   = div_r + 1'b1;
            state_nxt = prc_pkg::ST_CAND;
          end
        end
      end
      prc_pkg::ST_NEXT: begin
        if (cand_r == hi_r) begin
          state_nxt = prc_pkg::ST_FINISH;
        end else begin
          cand_nxt  = cand_r + 1'b1;
          div_nxt   = VB'(prc_pkg::FIRST_DIVISOR);
          sq_nxt    = (VB + 1)'(prc_pkg::FIRST_SQUARE);
          state_nxt = prc_pkg::ST_CAND;
        end
      end
      prc_pkg::ST_FINISH: begin
        // wait for the result slot to free
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = prc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = prc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cand_r      <= '0;
      div_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cand_r      <= cand_nxt;
      div_r       <= div_nxt;
      count_r     <= count_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    hi_r        <= hi_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    shf_r       <= shf_nxt;
    bit_r       <= bit_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

/* hw/rtl/prc_checker.sv */
// prc_checker: port-level checks on the prime range counter core.
// Depends on prc_pkg; bound to prime_range_counter_core below.
module prc_checker #(
  parameter int unsigned VALUE_BITS = prc_pkg::VALUE_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VALUE_BITS:0] prime_count
);

  // result slot empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // an accepted request keeps the core busy next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core ready right after taking a request");

  // a result appears only from a busy core
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(prime_count))
    else $error("stalled result changed");

endmodule

bind prime_range_counter_core prc_checker #(.VALUE_BITS(VALUE_BITS)) u_prc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .prime_count (out_res.prime_count)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for prime_range_counter_core, driving range requests
// and checking each count against a trial-division predictor.
// Depends on prc_pkg, prc_in_if / prc_out_if and the core itself.
module tb;

  localparam int unsigned VALUE_BITS  = prc_pkg::VALUE_BITS_DEF;
  localparam int unsigned VALUE_MAX   = (1 << VALUE_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned IDLE_PCT    = 22;
  localparam int unsigned TAIL_CYCLES = 64;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS:0]   count_t;

  // Expected count, with the request it came from for reporting
  typedef struct {
    value_t lo;
    value_t hi;
    count_t prime_count;
  } count_expect_t;

  logic clk = 1'b0;
  logic rst_n;

  prc_in_if  #(.VALUE_BITS(VALUE_BITS)) req_if ();
  prc_out_if #(.VALUE_BITS(VALUE_BITS)) res_if ();

  prime_range_counter_core #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  count_expect_t pending_counts[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  bit            sender_gaps    = 1'b1;
  bit            receiver_stalls = 1'b1;

  // Clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Trial division, divisors from 2 while d*d <= n
  function automatic bit is_prime(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Primes within [lo, hi]; an empty range counts zero
  function automatic count_t count_primes(value_t lo, value_t hi);
    count_t          tally;
    longint unsigned n;
    tally = '0;
    if (lo <= hi) begin
      for (n = lo; n <= hi; n++) begin
        if (is_prime(n)) tally = tally + 1'b1;
      end
    end
    return tally;
  endfunction

  // Result sink: random back-pressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= receiver_stalls ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_counts.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual prime_count %0d", $time,
                 res_if.prime_count);
      end else if (res_if.prime_count !== pending_counts[0].prime_count) begin
        mismatch_count++;
        $display("%0t: range [%0d, %0d] expected prime_count %0d, actual %0d", $time,
                 pending_counts[0].lo, pending_counts[0].hi,
                 pending_counts[0].prime_count, res_if.prime_count);
        void'(pending_counts.pop_front());
      end else begin
        void'(pending_counts.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_counts.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Send one request; valid is left high on return
  task automatic send_range(int unsigned lo, int unsigned hi);
    count_expect_t exp_item;
    @(negedge clk);
    while (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.range_start <= value_t'(lo);
    req_if.range_end   <= value_t'(hi);
    do @(posedge clk); while (!req_if.ready);
    exp_item.lo          = value_t'(lo);
    exp_item.hi          = value_t'(hi);
    exp_item.prime_count = count_primes(value_t'(lo), value_t'(hi));
    pending_counts.push_back(exp_item);
  endtask

  task automatic release_request();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // Mostly short ranges anywhere; some low wide ranges, some at the top, some empty
  task automatic send_random_range();
    int unsigned kind;
    int unsigned lo;
    int unsigned hi;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      lo = $urandom_range(0, VALUE_MAX);
      hi = lo + $urandom_range(0, 12);
    end else if (kind < 82) begin
      lo = $urandom_range(0, 400);
      hi = lo + $urandom_range(0, 120);
    end else if (kind < 90) begin
      lo = VALUE_MAX - $urandom_range(0, 16);
      hi = VALUE_MAX;
    end else begin
      hi = $urandom_range(0, VALUE_MAX - 1);
      lo = hi + $urandom_range(1, 300);
    end
    if (lo > VALUE_MAX) lo = VALUE_MAX;
    if (hi > VALUE_MAX) hi = VALUE_MAX;
    send_range(lo, hi);
  endtask

  // Smallest values, first squares and a low prime run
  task automatic test_small_values();
    send_range(0, 0);
    send_range(1, 1);
    send_range(0, 1);
    send_range(2, 2);
    send_range(3, 3);
    send_range(4, 4);
    send_range(9, 9);
    send_range(25, 25);
    send_range(0, 2);
    send_range(0, 30);
    send_range(0, 500);
  endtask

  // start > end gives zero without walking
  task automatic test_empty_ranges();
    send_range(5, 4);
    send_range(VALUE_MAX, 0);
    send_range(1, 0);
    send_range(VALUE_MAX, VALUE_MAX - 1);
  endtask

  // Walk ending on the largest value must not wrap
  task automatic test_top_of_range();
    send_range(VALUE_MAX, VALUE_MAX);
    send_range(VALUE_MAX - 1, VALUE_MAX);
    send_range(VALUE_MAX - 40, VALUE_MAX);
    send_range(VALUE_MAX - 2, VALUE_MAX - 1);
  endtask

  // Sender holds off until the core has drained
  task automatic test_drain_pause();
    send_range(97, 113);
    send_range(1000, 1010);
    release_request();
    wait_for_results();
    send_range(7919, 7919);
  endtask

  // Long stretch with no idling on either side
  task automatic test_back_to_back();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (25) send_random_range();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Random ranges with idling on both sides
  task automatic test_random_ranges();
    repeat (53) send_random_range();
  endtask

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.range_start = '0;
    req_if.range_end   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_small_values();
    test_empty_ranges();
    test_top_of_range();
    test_drain_pause();
    test_back_to_back();
    test_random_ranges();
    release_request();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
